// ===== hdl/multilevel_priority_fifo_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_scheduler_assert.svh
// assertion macros shared by the scheduler modules
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_FIFO_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_PRIORITY_FIFO_SCHEDULER_ASSERT_SVH

// checked while out of reset
`define MLPFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MLPFS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/mlpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpfs_pkg
// shared constants, status codes and control types of the ready-queue scheduler
// ----------------------------------------------------------------------------
package mlpfs_pkg;

    // default geometry
    localparam int NUM_LEVELS_DEF  = 4;
    localparam int LEVEL_DEPTH_DEF = 16;

    // field widths
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 3;
    localparam int QUANT_W  = 16;

    // time slice after reset
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;

    // opcodes
    localparam logic OP_ENQUEUE  = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // take the input beat into the item registers
        logic exec;      // update queues, write or read the store
        logic load;      // fill the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_valid; // output register holds an untaken beat
    } t_stat;

endpackage

// ===== hdl/mlpfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlpfs_ctrl
// sequencer: capture an item, execute it, then load the result register
// ----------------------------------------------------------------------------
`include "multilevel_priority_fifo_scheduler_assert.svh"

module mlpfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output mlpfs_pkg::t_cmd   o_cmd,
    input  mlpfs_pkg::t_stat  i_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       out_free;
    logic       in_acc;

    // output register can take a result this cycle
    assign out_free = !i_stat.out_valid || i_out_ready;

    // a new item is taken when idle or while the previous result is loaded
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_LOAD) && out_free);
    assign in_acc     = i_in_valid && o_in_ready;

    assign o_cmd.capture = in_acc;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_LOAD) && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) n_state = in_acc ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MLPFS_ASSERT(a_exec_then_load, (r_state == S_EXEC) |=> (r_state == S_LOAD), "exec not followed by load")
    `MLPFS_ASSERT(a_accept_to_exec, (i_in_valid && o_in_ready) |=> (r_state == S_EXEC), "accepted item not executed")
    `MLPFS_ASSERT(a_load_when_free, o_cmd.load |-> (!i_stat.out_valid || i_out_ready), "result loaded over untaken beat")

endmodule

// ===== hdl/mlpfs_datapath.sv =====
// ----------------------------------------------------------------------------
// mlpfs_datapath
// id store, per-level queue pointers and counts, result register
// ----------------------------------------------------------------------------
`include "multilevel_priority_fifo_scheduler_assert.svh"

module mlpfs_datapath #(
    parameter int NUM_LEVELS  = mlpfs_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mlpfs_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mlpfs_pkg::t_cmd                 i_cmd,
    output mlpfs_pkg::t_stat                o_stat,
    input  logic                            i_opcode,
    input  logic [mlpfs_pkg::ID_W-1:0]      i_process_id,
    input  logic [mlpfs_pkg::PRIO_W-1:0]    i_priority_level,
    input  logic                            i_cfg_we,
    input  logic [mlpfs_pkg::QUANT_W-1:0]   i_cfg_wdata,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mlpfs_pkg::STATUS_W-1:0]  o_status,
    output logic [mlpfs_pkg::ID_W-1:0]      o_dispatched_id,
    output logic [mlpfs_pkg::PRIO_W-1:0]    o_dispatched_level,
    output logic [mlpfs_pkg::QUANT_W-1:0]   o_quantum_given
);

    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_D  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    // captured item
    logic                          r_op;
    logic [mlpfs_pkg::ID_W-1:0]    r_pid;
    logic [mlpfs_pkg::PRIO_W-1:0]  r_prio;

    // queue control
    logic [PTR_W-1:0] r_heads  [NUM_LEVELS];
    logic [PTR_W-1:0] r_tails  [NUM_LEVELS];
    logic [CNT_W-1:0] r_counts [NUM_LEVELS];

    // id store
    logic [mlpfs_pkg::ID_W-1:0] r_mem [MEM_D];
    logic [mlpfs_pkg::ID_W-1:0] r_rd_data;

    // execution result
    logic [mlpfs_pkg::STATUS_W-1:0] r_res_status;
    logic [LVL_W-1:0]               r_res_level;

    // configuration
    logic [mlpfs_pkg::QUANT_W-1:0] r_quantum;

    // result register
    logic                           r_out_valid;
    logic [mlpfs_pkg::STATUS_W-1:0] r_out_status;
    logic [mlpfs_pkg::ID_W-1:0]     r_out_id;
    logic [mlpfs_pkg::PRIO_W-1:0]   r_out_level;
    logic [mlpfs_pkg::QUANT_W-1:0]  r_out_quant;

    logic                           any_ready;
    logic [LVL_W-1:0]               disp_lvl;
    logic [LVL_W-1:0]               sel_lvl;
    logic                           prio_bad;
    logic                           lvl_full;
    logic                           do_enq;
    logic                           do_deq;
    logic [PTR_W-1:0]               sel_ptr;
    logic [PTR_W-1:0]               n_ptr;
    logic [ADDR_W-1:0]              mem_addr;
    logic [mlpfs_pkg::STATUS_W-1:0] n_status;

    // capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_pid  <= i_process_id;
            r_prio <= i_priority_level;
        end
    end

    // most urgent non-empty level
    always_comb begin
        any_ready = 1'b0;
        disp_lvl  = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_counts[l] != '0) begin
                any_ready = 1'b1;
                disp_lvl  = LVL_W'(l);
            end
        end
    end

    // level selection and checks
    assign sel_lvl  = (r_op == mlpfs_pkg::OP_DISPATCH) ? disp_lvl : r_prio[LVL_W-1:0];
    assign prio_bad = ({1'b0, r_prio} >= (mlpfs_pkg::PRIO_W + 1)'(NUM_LEVELS));
    assign lvl_full = (r_counts[sel_lvl] == CNT_W'(LEVEL_DEPTH));
    assign do_enq   = i_cmd.exec && (r_op == mlpfs_pkg::OP_ENQUEUE) && !prio_bad && !lvl_full;
    assign do_deq   = i_cmd.exec && (r_op == mlpfs_pkg::OP_DISPATCH) && any_ready;

    // pointer of the selected level and its wrapped successor
    assign sel_ptr  = (r_op == mlpfs_pkg::OP_DISPATCH) ? r_heads[sel_lvl] : r_tails[sel_lvl];
    assign n_ptr    = (sel_ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : sel_ptr + 1'b1;
    assign mem_addr = ADDR_W'(sel_lvl * LEVEL_DEPTH) + ADDR_W'(sel_ptr);

    // result status of the item
    always_comb begin
        if (r_op == mlpfs_pkg::OP_DISPATCH) begin
            n_status = any_ready ? mlpfs_pkg::ST_DISPATCHED : mlpfs_pkg::ST_EMPTY;
        end else if (prio_bad) begin
            n_status = mlpfs_pkg::ST_BAD_PRIO;
        end else if (lvl_full) begin
            n_status = mlpfs_pkg::ST_FULL;
        end else begin
            n_status = mlpfs_pkg::ST_ENQUEUED;
        end
    end

    // queue pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_heads[l]  <= '0;
                r_tails[l]  <= '0;
                r_counts[l] <= '0;
            end
        end else if (do_enq) begin
            r_tails[sel_lvl]  <= n_ptr;
            r_counts[sel_lvl] <= r_counts[sel_lvl] + 1'b1;
        end else if (do_deq) begin
            r_heads[sel_lvl]  <= n_ptr;
            r_counts[sel_lvl] <= r_counts[sel_lvl] - 1'b1;
        end
    end

    // id store, at most one write or one registered read per item
    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[mem_addr] <= r_pid;
        end
        if (do_deq) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // execution result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= n_status;
            r_res_level  <= sel_lvl;
        end
    end

    // time slice register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= mlpfs_pkg::QUANTUM_RESET;
        end else if (i_cfg_we) begin
            r_quantum <= i_cfg_wdata;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= r_res_status;
            if (r_res_status == mlpfs_pkg::ST_DISPATCHED) begin
                r_out_id    <= r_rd_data;
                r_out_level <= mlpfs_pkg::PRIO_W'(r_res_level);
                r_out_quant <= r_quantum;
            end else begin
                r_out_id    <= '0;
                r_out_level <= '0;
                r_out_quant <= '0;
            end
        end
    end

    assign o_stat.out_valid   = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_dispatched_id    = r_out_id;
    assign o_dispatched_level = r_out_level;
    assign o_quantum_given    = r_out_quant;

    `MLPFS_ASSERT(a_load_sets_valid, i_cmd.load |=> o_out_valid, "loaded result not presented")
    `MLPFS_ASSERT(a_zero_fields, (o_out_valid && (o_status != mlpfs_pkg::ST_DISPATCHED)) |-> ((o_dispatched_id == '0) && (o_quantum_given == '0)), "non-dispatch result carries data")
    `MLPFS_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

// ===== hdl/multilevel_priority_fifo_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_scheduler
// ready-queue scheduler with one id fifo per priority level
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one beat per request:
// enqueue appends i_process_id to the fifo of i_priority_level, dispatch
// pops the head of the lowest-numbered non-empty level. Every request
// yields exactly one beat on the output channel (o_out_valid / i_out_ready)
// with a status code; a successful dispatch also carries id, level and time slice.
// The time slice is written through i_cfg_we / i_cfg_wdata, by the user only while idle (not enforced by the block).
// An accepted request is captured, then executed (queue update with store
// access), then loaded into the result register, which presents it.
// No new request is taken during the execute step; the next request is
// taken in the load step, once the output register is free.
// Reset clears all queue pointers and counts, drops any pending result and
// restores the time slice to 10; the id store itself is not cleared.
// When the receiver stalls the result waits in the output register and the
// next request is taken and executed, then held until the register frees.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo_scheduler #(
    parameter int NUM_LEVELS  = mlpfs_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mlpfs_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic [mlpfs_pkg::ID_W-1:0]      i_process_id,
    input  logic [mlpfs_pkg::PRIO_W-1:0]    i_priority_level,
    input  logic                            i_cfg_we,
    input  logic [mlpfs_pkg::QUANT_W-1:0]   i_cfg_wdata,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mlpfs_pkg::STATUS_W-1:0]  o_status,
    output logic [mlpfs_pkg::ID_W-1:0]      o_dispatched_id,
    output logic [mlpfs_pkg::PRIO_W-1:0]    o_dispatched_level,
    output logic [mlpfs_pkg::QUANT_W-1:0]   o_quantum_given
);

    mlpfs_pkg::t_cmd  cmd;
    mlpfs_pkg::t_stat stat;

    // sequencer
    mlpfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // queues, store and result register
    mlpfs_datapath #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_opcode           (i_opcode),
        .i_process_id       (i_process_id),
        .i_priority_level   (i_priority_level),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_dispatched_id    (o_dispatched_id),
        .o_dispatched_level (o_dispatched_level),
        .o_quantum_given    (o_quantum_given)
    );

endmodule
